// ===== src/rssc_pkg.sv =====
package rssc_pkg;

   // Queue sizing and counter width.
   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_BITS  = 8;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam int REFLECT_BITS = 10;
   localparam int STEP_BITS    = 7;
   localparam int WAIT_BITS    = 5;
   localparam int TYPE_BITS    = 3;
   localparam int CSR_IDX_BITS = 2;

   // Event codes.
   localparam logic [2:0] OP_ENTER  = 3'd0;
   localparam logic [2:0] OP_SAMPLE = 3'd1;
   localparam logic [2:0] OP_LEAVE  = 3'd2;
   localparam logic [2:0] OP_EOT    = 3'd3;
   localparam logic [2:0] OP_TICK   = 3'd4;
   localparam logic [2:0] OP_PAUSE  = 3'd5;

   // Bin codes, and the queue code of an entry not yet classified.
   localparam logic [1:0] BIN_BLACK    = 2'd0;
   localparam logic [1:0] BIN_ALUMINUM = 2'd1;
   localparam logic [1:0] BIN_WHITE    = 2'd2;
   localparam logic [1:0] BIN_STEEL    = 2'd3;
   localparam logic [TYPE_BITS-1:0] TYPE_UNCLASSIFIED = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALUMINUM_MAX = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEEL_MAX    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WHITE_MAX    = 2'd2;

   localparam logic [REFLECT_BITS-1:0] REFLECT_MAX       = 10'd1023;
   localparam logic [REFLECT_BITS-1:0] ALUMINUM_MAX_INIT = 10'd350;
   localparam logic [REFLECT_BITS-1:0] STEEL_MAX_INIT    = 10'd699;
   localparam logic [REFLECT_BITS-1:0] WHITE_MAX_INIT    = 10'd940;

   localparam logic [STEP_BITS-1:0] QUARTER_STEPS = 7'd50;
   localparam logic [STEP_BITS-1:0] HALF_STEPS    = 7'd100;

   localparam logic [5:0] COIL_TABLE [4] = '{6'h36, 6'h2E, 6'h2D, 6'h35};

   localparam logic [WAIT_BITS-1:0] RAMP_QUARTER [50] = '{
      5'd20, 5'd17, 5'd15, 5'd14, 5'd13, 5'd11, 5'd11, 5'd10, 5'd9,  5'd9,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd9,  5'd9,  5'd10, 5'd11, 5'd11, 5'd13, 5'd14, 5'd15, 5'd17, 5'd20};

   localparam logic [WAIT_BITS-1:0] RAMP_HALF [100] = '{
      5'd20, 5'd19, 5'd17, 5'd16, 5'd15, 5'd15, 5'd14, 5'd13, 5'd13, 5'd12,
      5'd11, 5'd11, 5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd9,  5'd8,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd9,  5'd9,  5'd9,  5'd9,  5'd10, 5'd10, 5'd11, 5'd11, 5'd11,
      5'd12, 5'd13, 5'd13, 5'd14, 5'd15, 5'd15, 5'd16, 5'd17, 5'd19, 5'd20};

   typedef struct packed {
      logic [2:0]              op;
      logic [REFLECT_BITS-1:0] sample;
   } req_word_type;

   typedef struct packed {
      logic [5:0] coil_pattern;
      logic       belt_run;
      logic       moving;
      logic [1:0] bin_position;
      logic [7:0] count_black;
      logic [7:0] count_aluminum;
      logic [7:0] count_white;
      logic [7:0] count_steel;
      logic [4:0] queue_count;
      logic       queue_overflow;
   } rsp_word_type;

   // Write port of the type queue memory.
   typedef struct packed {
      logic                 en;
      logic [QPTR_BITS-1:0] addr;
      logic [TYPE_BITS-1:0] data;
   } ram_wr_type;

   // Millisecond wait after a step, looked up by move length and step number.
   function automatic logic [WAIT_BITS-1:0] ramp_wait(input logic quarter,
                                                      input logic [STEP_BITS-1:0] idx);
      logic [5:0] q_idx;
      logic [6:0] h_idx;
      q_idx = (idx < QUARTER_STEPS) ? idx[5:0] : 6'(QUARTER_STEPS - 7'd1);
      h_idx = (idx < HALF_STEPS) ? idx : (HALF_STEPS - 7'd1);
      return quarter ? RAMP_QUARTER[q_idx] : RAMP_HALF[h_idx];
   endfunction

endpackage

// ===== src/rssc_type_ram.sv =====
module rssc_type_ram (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [rssc_pkg::QPTR_BITS-1:0] rd_addr,
   input  rssc_pkg::ram_wr_type           wr,
   output logic [rssc_pkg::TYPE_BITS-1:0] rd_data
);
   import rssc_pkg::*;

   logic [TYPE_BITS-1:0] mem [QUEUE_DEPTH];
   logic [TYPE_BITS-1:0] rd_data_ff;

   // A write to the address being read in the same cycle is passed through.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= (wr.en && (wr.addr == rd_addr)) ? wr.data : mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/reflect_sort_stepper_controller.sv =====
// Conveyor sorter controller. Each word on the req channel is one event (object enter,
// reflectance sample, object leave, end of travel, millisecond tick, pause press), and
// each accepted word yields exactly one rsp word showing the state after that event:
// coil pattern, belt drive, move status, bin position, the four saturating bin counts,
// the queue fill and the sticky overflow flag. The block takes one word per clock cycle
// while responses are taken. Each word passes through the accept stage, which issues
// the read of the queue head in the type memory, then the execute stage, which uses
// the read data and updates all state; its response is then registered on the rsp
// port. A write that is issued during the same cycle as a read of the same entry is
// forwarded, so words follow each other without gaps. A registered output stage
// separates the two sides, so one more word is still accepted while a response waits
// to be taken; after that the input stalls until the waiting response is taken.
// The type memory starts out unwritten and needs no clearing pass, since only
// entries written by a push are ever used. Threshold registers should be written
// through the csr port only while no words are in flight.
module reflect_sort_stepper_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rssc_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rssc_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_write_en,
   input  logic [rssc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [rssc_pkg::REFLECT_BITS-1:0] csr_data
);
   import rssc_pkg::*;

   // Thresholds.
   logic [REFLECT_BITS-1:0] aluminum_max_ff, steel_max_ff, white_max_ff;

   // Execute stage and output stage.
   logic         exe_valid_ff, exe_valid_in;
   req_word_type exe_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         out_free, exe_fire, req_fire;

   // Controller state.
   logic [QPTR_BITS-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [QFILL_BITS-1:0]   fill_ff, fill_in;
   logic [REFLECT_BITS-1:0] min_ff, min_in;
   logic [1:0]              bin_ff, bin_in, phase_ff, phase_in;
   logic                    dir_ff, dir_in, quarter_ff, quarter_in;
   logic [STEP_BITS-1:0]    step_ff, step_in, total_ff, total_in;
   logic [WAIT_BITS-1:0]    wait_ff, wait_in;
   logic                    busy_ff, busy_in, paused_ff, paused_in;
   logic                    overflow_ff, overflow_in;
   logic [COUNT_BITS-1:0]   count_ff [4];
   logic [COUNT_BITS-1:0]   count_in [4];

   // Type memory.
   ram_wr_type           ram_wr;
   logic [TYPE_BITS-1:0] ram_rd_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign exe_fire  = exe_valid_ff && out_free;
   assign req_ready = !exe_valid_ff || exe_fire;
   assign req_fire  = req_valid && req_ready;

   // The head read for the incoming word uses the head as it stands after the word
   // now executing, so a pop in the execute stage is already accounted for.
   rssc_type_ram u_type_ram (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (head_in),
      .wr      (ram_wr),
      .rd_data (ram_rd_data)
   );

   always_comb begin : exec_logic
      logic [QPTR_BITS-1:0]  newest;
      logic [TYPE_BITS-1:0]  cls;
      logic [1:0]            d;
      logic [1:0]            delta;
      logic [STEP_BITS-1:0]  step_next;

      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      min_in      = min_ff;
      bin_in      = bin_ff;
      phase_in    = phase_ff;
      dir_in      = dir_ff;
      quarter_in  = quarter_ff;
      step_in     = step_ff;
      total_in    = total_ff;
      wait_in     = wait_ff;
      busy_in     = busy_ff;
      paused_in   = paused_ff;
      overflow_in = overflow_ff;
      count_in    = count_ff;
      ram_wr      = '0;

      newest = (tail_ff == '0) ? QPTR_BITS'(QUEUE_DEPTH - 1) : tail_ff - 1'b1;

      // First threshold that matches wins; black above all three.
      if (min_ff <= aluminum_max_ff) begin
         cls = {1'b0, BIN_ALUMINUM};
      end else if (min_ff <= steel_max_ff) begin
         cls = {1'b0, BIN_STEEL};
      end else if (min_ff <= white_max_ff) begin
         cls = {1'b0, BIN_WHITE};
      end else begin
         cls = {1'b0, BIN_BLACK};
      end

      d         = ram_rd_data[1:0] - bin_ff;
      delta     = quarter_ff ? (dir_ff ? 2'd3 : 2'd1) : 2'd2;
      step_next = step_ff + 1'b1;

      if (exe_fire) begin
         unique case (exe_word_ff.op)
            OP_ENTER: begin
               min_in = REFLECT_MAX;
               if (fill_ff == QFILL_BITS'(QUEUE_DEPTH)) begin
                  overflow_in = 1'b1;
               end else begin
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = tail_ff;
                  ram_wr.data = TYPE_UNCLASSIFIED;
                  tail_in = (tail_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
            OP_SAMPLE: begin
               if (exe_word_ff.sample < min_ff) begin
                  min_in = exe_word_ff.sample;
               end
            end
            OP_LEAVE: begin
               if (fill_ff != '0) begin
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = newest;
                  ram_wr.data = cls;
               end
            end
            OP_EOT: begin
               if (!busy_ff && (fill_ff != '0)) begin
                  head_in = (head_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  fill_in = fill_ff - 1'b1;
                  // An unclassified entry is dropped without a move or a count.
                  if (ram_rd_data != TYPE_UNCLASSIFIED && !ram_rd_data[2]) begin
                     if (count_ff[ram_rd_data[1:0]] != '1) begin
                        count_in[ram_rd_data[1:0]] = count_ff[ram_rd_data[1:0]] + 1'b1;
                     end
                     if (d != 2'd0) begin
                        dir_in     = (d != 2'd1);
                        quarter_in = (d != 2'd2);
                        total_in   = (d != 2'd2) ? QUARTER_STEPS : HALF_STEPS;
                        step_in    = '0;
                        busy_in    = 1'b1;
                        phase_in   = (d != 2'd1) ? phase_ff - 1'b1 : phase_ff + 1'b1;
                        wait_in    = ramp_wait(d != 2'd2, '0);
                     end
                  end
               end
            end
            OP_TICK: begin
               if (busy_ff) begin
                  if (wait_ff > WAIT_BITS'(1)) begin
                     wait_in = wait_ff - 1'b1;
                  end else if (step_next >= total_ff) begin
                     bin_in  = bin_ff + delta;
                     busy_in = 1'b0;
                     wait_in = '0;
                     step_in = '0;
                  end else begin
                     step_in  = step_next;
                     phase_in = dir_ff ? phase_ff - 1'b1 : phase_ff + 1'b1;
                     wait_in  = ramp_wait(quarter_ff, step_next);
                  end
               end
            end
            OP_PAUSE: begin
               paused_in = !paused_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Response shows the state after the executed word.
   always_comb begin
      rsp_word_in.coil_pattern   = COIL_TABLE[phase_in];
      rsp_word_in.belt_run       = !busy_in && !paused_in;
      rsp_word_in.moving         = busy_in;
      rsp_word_in.bin_position   = bin_in;
      rsp_word_in.count_black    = 8'(count_in[BIN_BLACK]);
      rsp_word_in.count_aluminum = 8'(count_in[BIN_ALUMINUM]);
      rsp_word_in.count_white    = 8'(count_in[BIN_WHITE]);
      rsp_word_in.count_steel    = 8'(count_in[BIN_STEEL]);
      rsp_word_in.queue_count    = 5'(fill_in);
      rsp_word_in.queue_overflow = overflow_in;
   end

   assign exe_valid_in = req_fire ? 1'b1 : (exe_fire ? 1'b0 : exe_valid_ff);
   assign rsp_valid_in = exe_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         aluminum_max_ff <= ALUMINUM_MAX_INIT;
         steel_max_ff    <= STEEL_MAX_INIT;
         white_max_ff    <= WHITE_MAX_INIT;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ALUMINUM_MAX: aluminum_max_ff <= csr_data;
            CSR_STEEL_MAX:    steel_max_ff    <= csr_data;
            CSR_WHITE_MAX:    white_max_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         min_ff       <= REFLECT_MAX;
         bin_ff       <= BIN_BLACK;
         phase_ff     <= '0;
         dir_ff       <= 1'b0;
         quarter_ff   <= 1'b0;
         step_ff      <= '0;
         total_ff     <= '0;
         wait_ff      <= '0;
         busy_ff      <= 1'b0;
         paused_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
         count_ff     <= '{default: '0};
      end else begin
         exe_valid_ff <= exe_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         min_ff       <= min_in;
         bin_ff       <= bin_in;
         phase_ff     <= phase_in;
         dir_ff       <= dir_in;
         quarter_ff   <= quarter_in;
         step_ff      <= step_in;
         total_ff     <= total_in;
         wait_ff      <= wait_in;
         busy_ff      <= busy_in;
         paused_ff    <= paused_in;
         overflow_ff  <= overflow_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         exe_word_ff <= req_word;
      end
      if (exe_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Head plus fill, wrapped, must land on the tail.
   logic [QFILL_BITS:0] head_plus_fill;
   logic [QPTR_BITS-1:0] head_plus_fill_wrap;
   assign head_plus_fill = (QFILL_BITS + 1)'(head_ff) + (QFILL_BITS + 1)'(fill_ff);
   assign head_plus_fill_wrap = (head_plus_fill >= (QFILL_BITS + 1)'(QUEUE_DEPTH))
      ? QPTR_BITS'(head_plus_fill - (QFILL_BITS + 1)'(QUEUE_DEPTH))
      : QPTR_BITS'(head_plus_fill);

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QFILL_BITS'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      head_plus_fill_wrap == tail_ff)
      else $error("queue pointers disagree with fill");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (wait_ff == '0) && (step_ff == '0))
      else $error("step state left over after move");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff < total_ff) && (wait_ff != '0))
      else $error("step index or wait out of range during move");

   a_exec_responds: assert property (@(posedge clock) disable iff (reset)
      exe_fire |=> rsp_valid_ff)
      else $error("executed word produced no response");

endmodule
